// File: rtl/mlrq_pkg.sv
package mlrq_pkg;

  // Table sizes of the ready queue.
  localparam int NUM_LEVELS = 8;
  localparam int NUM_IDS    = 16;

  localparam int ID_W   = $clog2(NUM_IDS);
  localparam int LINK_W = ID_W + 1;
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PRIO_W = 4;

  // Highest level a push may land on (the priority field never reaches past 8).
  localparam int TOP_LEVEL = (NUM_LEVELS - 1 < 8) ? NUM_LEVELS - 1 : 8;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // Link value that means "no entry".
  localparam link_t NIL_LINK = link_t'(NUM_IDS);

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2
  } status_t;

endpackage

// File: rtl/multilevel_ready_queue.sv
// Multilevel ready queue of process ids, one FIFO per priority level.
// Input channel (in_*): one request per accepted beat. in_tuser carries the
// operation (push, pop highest, remove by id, find by id); in_tdata carries
// the process id and, for a push, its signed priority. The level of an id is
// its priority plus one, clamped to the level range, and level 0 is served
// first.
// Result channel (out_*): exactly one result per request. out_tuser carries
// the status (ok, empty or not found, already queued); out_tdata carries the
// id and priority involved, both zero when the status is not ok.
// The result of an accepted request is registered and presented from the next
// clock edge on. Every request completes through the link tables and a
// priority encoder over the level heads, so one request per cycle is sustained
// while the receiver takes each result as it is presented.
// The result register acts as the output stage: a new request is taken in
// the same cycle that the previous result is taken, and while the receiver
// stalls the result holds and in_tready stays low.
// Reset (synchronous, rst_n low) empties every level and clears all queued
// flags; the link and level tables need no clearing since they are only read
// for queued ids.
module multilevel_ready_queue (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] proc_id, [7:4] prio (signed)
  input  logic [1:0] in_tuser,   // [1:0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] out_id, [7:4] out_prio (signed)
  output logic [1:0] out_tuser   // [1:0] status
);

  localparam int NL = mlrq_pkg::NUM_LEVELS;
  localparam int NI = mlrq_pkg::NUM_IDS;

  // Level heads and tails, reset to empty.
  mlrq_pkg::link_t head_r [NL];
  mlrq_pkg::link_t tail_r [NL];
  mlrq_pkg::link_t head_nxt [NL];
  mlrq_pkg::link_t tail_nxt [NL];

  // Per-id tables. Links and levels are only meaningful while the id is queued.
  mlrq_pkg::link_t next_r [NI];
  mlrq_pkg::link_t prev_r [NI];
  mlrq_pkg::lvl_t  lvl_r  [NI];
  mlrq_pkg::link_t next_nxt [NI];
  mlrq_pkg::link_t prev_nxt [NI];
  mlrq_pkg::lvl_t  lvl_nxt  [NI];
  logic [NI-1:0]   queued_r;
  logic [NI-1:0]   queued_nxt;

  // Result register.
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic [1:0]       out_user_r;
  logic [7:0]       out_data_nxt;
  logic [1:0]       out_user_nxt;

  logic             accept;
  mlrq_pkg::op_t    op;
  mlrq_pkg::id_t    req_id;
  logic signed [4:0] push_lvl_s;
  mlrq_pkg::lvl_t   push_lvl;

  // Pop search and the shared unlink path.
  logic             pop_found;
  mlrq_pkg::lvl_t   pop_lvl;
  mlrq_pkg::id_t    pop_id;
  mlrq_pkg::id_t    ul_id;
  mlrq_pkg::lvl_t   ul_lvl;
  mlrq_pkg::link_t  ul_prev;
  mlrq_pkg::link_t  ul_next;
  logic             ul_prev_ok;
  logic             ul_next_ok;
  mlrq_pkg::link_t  push_tail;
  mlrq_pkg::status_t res_status;
  mlrq_pkg::id_t    res_id;
  mlrq_pkg::lvl_t   res_lvl;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign op     = mlrq_pkg::op_t'(in_tuser);
  assign req_id = in_tdata[3:0];

  // Level of a pushed id is priority plus one, clamped to the level range.
  assign push_lvl_s = {in_tdata[7], in_tdata[7:4]} + 5'sd1;
  always_comb begin
    if (push_lvl_s < 5'sd0) begin
      push_lvl = '0;
    end else if (push_lvl_s > 5'(mlrq_pkg::TOP_LEVEL)) begin
      push_lvl = mlrq_pkg::LVL_W'(mlrq_pkg::TOP_LEVEL);
    end else begin
      push_lvl = push_lvl_s[mlrq_pkg::LVL_W-1:0];
    end
  end

  // Priority encoder: lowest-numbered level that holds an id.
  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (head_r[i] < mlrq_pkg::NIL_LINK) begin
        pop_found = 1'b1;
        pop_lvl   = mlrq_pkg::LVL_W'(i);
      end
    end
  end
  assign pop_id = head_r[pop_lvl][mlrq_pkg::ID_W-1:0];

  // The unlink path serves both pop (the head found) and remove (the given id).
  assign ul_id      = (op == mlrq_pkg::OP_POP) ? pop_id : req_id;
  assign ul_lvl     = lvl_r[ul_id];
  assign ul_prev    = prev_r[ul_id];
  assign ul_next    = next_r[ul_id];
  assign ul_prev_ok = ul_prev < mlrq_pkg::NIL_LINK;
  assign ul_next_ok = ul_next < mlrq_pkg::NIL_LINK;
  assign push_tail  = tail_r[push_lvl];

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    next_nxt   = next_r;
    prev_nxt   = prev_r;
    lvl_nxt    = lvl_r;
    queued_nxt = queued_r;
    res_status = mlrq_pkg::ST_NOT_FOUND;
    res_id     = req_id;
    res_lvl    = lvl_r[req_id];

    case (op)
      mlrq_pkg::OP_PUSH: begin
        res_lvl = push_lvl;
        if (queued_r[req_id]) begin
          res_status = mlrq_pkg::ST_DUPLICATE;
        end else begin
          res_status       = mlrq_pkg::ST_OK;
          lvl_nxt[req_id]  = push_lvl;
          next_nxt[req_id] = mlrq_pkg::NIL_LINK;
          prev_nxt[req_id] = push_tail;
          if (push_tail < mlrq_pkg::NIL_LINK) begin
            next_nxt[push_tail[mlrq_pkg::ID_W-1:0]] = {1'b0, req_id};
          end else begin
            head_nxt[push_lvl] = {1'b0, req_id};
          end
          tail_nxt[push_lvl]  = {1'b0, req_id};
          queued_nxt[req_id]  = 1'b1;
        end
      end
      mlrq_pkg::OP_POP, mlrq_pkg::OP_REMOVE: begin
        if (op == mlrq_pkg::OP_POP) begin
          res_id  = pop_id;
          res_lvl = pop_lvl;
        end
        if ((op == mlrq_pkg::OP_POP) ? pop_found : queued_r[req_id]) begin
          res_status = mlrq_pkg::ST_OK;
          if (ul_prev_ok) begin
            next_nxt[ul_prev[mlrq_pkg::ID_W-1:0]] = ul_next;
          end else begin
            head_nxt[ul_lvl] = ul_next_ok ? ul_next : mlrq_pkg::NIL_LINK;
          end
          if (ul_next_ok) begin
            prev_nxt[ul_next[mlrq_pkg::ID_W-1:0]] = ul_prev;
          end else begin
            tail_nxt[ul_lvl] = ul_prev_ok ? ul_prev : mlrq_pkg::NIL_LINK;
          end
          queued_nxt[ul_id] = 1'b0;
        end
      end
      mlrq_pkg::OP_FIND: begin
        if (queued_r[req_id]) begin
          res_status = mlrq_pkg::ST_OK;
        end
      end
      default: begin
        res_status = mlrq_pkg::ST_NOT_FOUND;
      end
    endcase

    // Priority is level minus one; id and priority read zero unless ok.
    out_user_nxt = res_status;
    if (res_status == mlrq_pkg::ST_OK) begin
      out_data_nxt = {mlrq_pkg::PRIO_W'(res_lvl) - mlrq_pkg::PRIO_W'(1), res_id};
    end else begin
      out_data_nxt = '0;
    end
  end

  // Control state and level pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      queued_r    <= '0;
      for (int i = 0; i < NL; i++) begin
        head_r[i] <= mlrq_pkg::NIL_LINK;
        tail_r[i] <= mlrq_pkg::NIL_LINK;
      end
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        queued_r    <= queued_nxt;
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: link tables and the result data.
  always_ff @(posedge clk) begin
    if (accept) begin
      next_r     <= next_nxt;
      prev_r     <= prev_nxt;
      lvl_r      <= lvl_nxt;
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

// File: test/multilevel_ready_queue_test.sv
`timescale 1ns / 1ps

module multilevel_ready_queue_test;
  import mlrq_pkg::*;

  typedef logic signed [PRIO_W-1:0] prio_t;

  // One request as the sender presents it on the input channel.
  typedef struct packed {
    op_t   op;
    id_t   id;
    prio_t prio;
  } request_t;

  // One result as the block should present it on the result channel.
  typedef struct packed {
    status_t status;
    id_t     id;
    prio_t   prio;
  } result_t;

  // Random items after the directed opening, and the final stretch of the run
  // in which neither side idles.
  localparam int RANDOM_REQUESTS = 1080;
  localparam int QUIET_TAIL      = 120;
  // The receiver's long hold-off starts after this many results.
  localparam int HOLD_AFTER      = 400;
  localparam int HOLD_CYCLES     = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  multilevel_ready_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // The clock runs with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests still to be offered, filled up front by the stimulus block.
  request_t pending_requests[$];
  // Results that accepted requests must still produce, oldest first.
  result_t  awaited_results[$];
  int       total_requests;
  int       mismatch_count;

  // Shadow of the ready queue. Each level is a FIFO, so among the ids queued
  // on one level the one pushed earliest is at the head. Keeping a push
  // sequence number per id gives the same order as the link tables without
  // having to track the links themselves.
  bit          shadow_queued[NUM_IDS];
  int          shadow_level[NUM_IDS];
  int unsigned shadow_seq[NUM_IDS];
  int unsigned push_counter;

  // Coverage tallies for the closing summary.
  int op_tally[4];
  int status_tally[3];

  // Applies one request to the shadow queue and returns the result that the
  // block must produce for it.
  function automatic result_t serve_request(input request_t req);
    result_t res;
    int      lvl;
    int      pick;
    res = '{status: ST_NOT_FOUND, id: '0, prio: '0};
    pick = -1;
    case (req.op)
      OP_PUSH: begin
        if (shadow_queued[req.id]) begin
          res.status = ST_DUPLICATE;
        end else begin
          // The level is the priority plus one, clamped to the level range.
          lvl = int'(req.prio) + 1;
          if (lvl < 0) lvl = 0;
          if (lvl > TOP_LEVEL) lvl = TOP_LEVEL;
          shadow_queued[req.id] = 1'b1;
          shadow_level[req.id] = lvl;
          shadow_seq[req.id] = push_counter;
          push_counter++;
          pick = req.id;
        end
      end
      OP_POP: begin
        // Lowest level wins; within a level, the earliest push.
        for (int i = 0; i < NUM_IDS; i++) begin
          if (shadow_queued[i] && (pick < 0 || shadow_level[i] < shadow_level[pick] ||
              (shadow_level[i] == shadow_level[pick] && shadow_seq[i] < shadow_seq[pick])))
            pick = i;
        end
        if (pick >= 0) shadow_queued[pick] = 1'b0;
      end
      OP_REMOVE: begin
        if (shadow_queued[req.id]) begin
          pick = req.id;
          shadow_queued[pick] = 1'b0;
        end
      end
      default: begin
        if (shadow_queued[req.id]) pick = req.id;
      end
    endcase
    if (pick >= 0) begin
      res.status = ST_OK;
      res.id = id_t'(pick);
      res.prio = prio_t'(shadow_level[pick] - 1);
    end
    return res;
  endfunction

  // Prints one line for a wrong or unexpected result field and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic void add_request(input op_t op, input int id, input int prio);
    request_t req;
    req.op = op;
    req.id = id_t'(id);
    req.prio = prio_t'(prio);
    pending_requests.push_back(req);
  endfunction

  // Sender. A new request is loaded whenever the current one has been taken
  // or none is on offer. After a request, the sender now and then pauses for
  // a random burst of cycles, except in the final stretch of the run.
  int       sender_gap;
  request_t next_request;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      sender_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (sender_gap > 0) begin
        sender_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        next_request = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {next_request.prio, next_request.id};
        in_tuser <= next_request.op;
        if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          sender_gap = $urandom_range(1, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. It stalls in random bursts, and once in the run it holds off
  // for a long stretch so that the result register stays full and the block
  // has to push back on the sender. HOLD_AFTER and HOLD_CYCLES set the long hold.
  int  results_taken;
  int  stall_left;
  bit  long_hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      results_taken = 0;
      stall_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_taken++;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && results_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (results_taken < total_requests - QUIET_TAIL &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor. A result taken at this edge belongs to a request accepted at an
  // earlier edge, so it is checked before the request accepted at this same
  // edge adds its own expectation.
  result_t  oldest_result;
  result_t  predicted;
  request_t accepted;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unrequested result, status", int'(out_tuser), -1);
        end else begin
          oldest_result = awaited_results.pop_front();
          if (out_tuser !== oldest_result.status)
            report_mismatch("status", int'(out_tuser), int'(oldest_result.status));
          if (out_tdata[3:0] !== oldest_result.id)
            report_mismatch("out_id", int'(out_tdata[3:0]), int'(oldest_result.id));
          if (out_tdata[7:4] !== oldest_result.prio)
            report_mismatch("out_prio", int'($signed(out_tdata[7:4])),
                            int'(oldest_result.prio));
        end
      end
      if (in_tvalid && in_tready) begin
        accepted.op = op_t'(in_tuser);
        accepted.id = in_tdata[3:0];
        accepted.prio = in_tdata[7:4];
        predicted = serve_request(accepted);
        awaited_results.push_back(predicted);
        op_tally[accepted.op]++;
        status_tally[predicted.status]++;
      end
    end
  end

  // Stimulus, reset and the end of the run.
  int draw;
  int push_weight;

  initial begin
    mismatch_count = 0;
    push_counter = 0;
    for (int i = 0; i < NUM_IDS; i++) begin
      shadow_queued[i] = 1'b0;
      shadow_level[i] = 0;
      shadow_seq[i] = 0;
    end

    // Directed opening: empty pop and misses, priority extremes on both
    // sides of the clamp, a push of an id that is already queued, removal
    // from the middle, tail and head of a level, and the service order.
    add_request(OP_POP, 0, 0);
    add_request(OP_FIND, 3, 0);
    add_request(OP_REMOVE, 3, 0);
    add_request(OP_PUSH, 0, -8);
    add_request(OP_PUSH, 15, 7);
    add_request(OP_PUSH, 5, -1);
    add_request(OP_PUSH, 9, 6);
    add_request(OP_PUSH, 7, 2);
    add_request(OP_PUSH, 12, 2);
    add_request(OP_PUSH, 4, 2);
    add_request(OP_PUSH, 7, 0);
    add_request(OP_FIND, 15, 0);
    add_request(OP_FIND, 12, 5);
    add_request(OP_REMOVE, 12, 0);
    add_request(OP_REMOVE, 4, 0);
    add_request(OP_POP, 0, 0);
    add_request(OP_POP, 0, 0);
    add_request(OP_POP, 0, 0);
    add_request(OP_REMOVE, 15, 0);
    add_request(OP_POP, 0, 0);
    add_request(OP_POP, 0, 0);
    add_request(OP_PUSH, 10, 3);
    add_request(OP_REMOVE, 10, 0);
    add_request(OP_FIND, 10, 0);

    // Random part. Phases alternate between filling and draining so that
    // the queue swings between empty and full, which brings on duplicate
    // pushes, empty pops and removals at every position of a level.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      push_weight = ((i / 50) % 2 == 0) ? 60 : 20;
      draw = $urandom_range(0, 99);
      if (draw < push_weight)
        add_request(OP_PUSH, $urandom_range(0, 15),
                    ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) - 1
                                               : $urandom_range(0, 15));
      else if (draw < push_weight + (100 - push_weight) / 2)
        add_request(OP_POP, $urandom_range(0, 15), $urandom_range(0, 15));
      else if (draw < push_weight + 3 * (100 - push_weight) / 4)
        add_request(OP_REMOVE, $urandom_range(0, 15), $urandom_range(0, 15));
      else
        add_request(OP_FIND, $urandom_range(0, 15), $urandom_range(0, 15));
    end
    total_requests = pending_requests.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Sampling on the falling edge keeps these checks clear of the updates
    // made at the rising edge.
    while (pending_requests.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (5) @(negedge clk);

    $display("Ran %0d requests: %0d push, %0d pop, %0d remove, %0d find.",
             total_requests, op_tally[OP_PUSH], op_tally[OP_POP],
             op_tally[OP_REMOVE], op_tally[OP_FIND]);
    $display("Results seen: %0d ok, %0d empty or not found, %0d already queued.",
             status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_DUPLICATE]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Run timed out with %0d results outstanding", awaited_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
